>>> sv/tfct_pkg.sv
// Package for the three-frame codon translator.
// Holds base codes, the codon table, the front-to-back command type and the back FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfct_pkg;

    localparam int HOLD_DEPTH_DEF      = 16;
    localparam int SEG_COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH         = 4;
    localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);
    localparam logic [4:0] MIN_LEN_RESET = 5'd8;

    typedef logic [2:0] base_code_t;
    localparam base_code_t BASE_T = 3'd0;
    localparam base_code_t BASE_C = 3'd1;
    localparam base_code_t BASE_A = 3'd2;
    localparam base_code_t BASE_G = 3'd3;
    localparam base_code_t BASE_N = 3'd4;

    localparam logic [7:0] AA_STOP    = "Z";
    localparam logic [7:0] AA_UNKNOWN = "X";

    // standard code, index = {b0, b1, b2} with T=0 C=1 A=2 G=3
    localparam logic [8*64-1:0] CODON_STR =
        "FFLLSSSSYYZZCCZWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";

    typedef struct packed {
        logic [7:0] aa;
        logic [1:0] frame;
        logic       last;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_DATA,
        BK_FLUSH
    } back_state_t;

    function automatic base_code_t base_code(input logic [7:0] ch);
        base_code_t code;
        unique case (ch)
            "T", "U": code = BASE_T;
            "C":      code = BASE_C;
            "A":      code = BASE_A;
            "G":      code = BASE_G;
            default:  code = BASE_N;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] codon_aa(input base_code_t b0, input base_code_t b1,
                                            input base_code_t b2);
        logic [5:0] idx;
        logic [7:0] aa;
        idx = {b0[1:0], b1[1:0], b2[1:0]};
        if (b0 == BASE_N || b1 == BASE_N || b2 == BASE_N) begin
            aa = AA_UNKNOWN;
        end else begin
            aa = CODON_STR[8*(63 - int'(idx)) +: 8];
        end
        return aa;
    endfunction

endpackage

`default_nettype wire

>>> sv/tfct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tfct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/tfct_front.sv
// Front end: accepts bases, tracks the last two bases and the frame phase,
// translates each completed codon into a command. Depends on tfct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfct_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_base_char,
    input  wire logic          s_last_base,
    input  wire logic          q_full,
    output logic               push,
    output tfct_pkg::cmd_t     cmd
);
    import tfct_pkg::*;

    base_code_t prev0_reg, prev0_next;
    base_code_t prev1_reg, prev1_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] warm_reg, warm_next;
    base_code_t cur;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign cur     = base_code(s_base_char);

    always_comb begin
        push      = accept && (warm_reg == 2'd2);
        cmd.aa    = codon_aa(prev0_reg, prev1_reg, cur);
        cmd.frame = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
        cmd.last  = s_last_base;
    end

    always_comb begin
        prev0_next = prev0_reg;
        prev1_next = prev1_reg;
        phase_next = phase_reg;
        warm_next  = warm_reg;
        if (accept) begin
            if (s_last_base) begin
                prev0_next = BASE_T;
                prev1_next = BASE_T;
                phase_next = 2'd0;
                warm_next  = 2'd0;
            end else begin
                prev0_next = prev1_reg;
                prev1_next = cur;
                phase_next = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
                warm_next  = (warm_reg == 2'd2) ? 2'd2 : warm_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev0_reg <= BASE_T;
            prev1_reg <= BASE_T;
            phase_reg <= 2'd0;
            warm_reg  <= 2'd0;
        end else begin
            prev0_reg <= prev0_next;
            prev1_reg <= prev1_next;
            phase_reg <= phase_next;
            warm_reg  <= warm_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/tfct_queue.sv
// Short command queue between front and back ends.
// Depends on tfct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfct_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire tfct_pkg::cmd_t cmd_in,
    output logic               full,
    input  wire logic          pop,
    output logic               valid,
    output tfct_pkg::cmd_t     cmd_out
);
    import tfct_pkg::*;

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, wptr_next;
    logic [QUEUE_AW-1:0] rptr_reg, rptr_next;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign cmd_out = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

>>> sv/tfct_back.sv
// Back end: per-frame segment state, held amino acids in RAM, result output register.
// Depends on tfct_pkg and tfct_ram.
`timescale 1ns / 1ps
`default_nettype none

module tfct_back #(
    parameter int HOLD_DEPTH      = tfct_pkg::HOLD_DEPTH_DEF,
    parameter int SEG_COUNT_WIDTH = tfct_pkg::SEG_COUNT_WIDTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [4:0]    min_segment_len,
    input  wire logic          q_valid,
    input  wire tfct_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_amino_acid,
    output logic [1:0]         m_frame_index,
    output logic [15:0]        m_segment_number,
    output logic               m_segment_end,
    output logic               m_last_of_run
);
    import tfct_pkg::*;

    localparam int CW        = $clog2(HOLD_DEPTH + 1);
    localparam int RAM_DEPTH = 3 * HOLD_DEPTH;
    localparam int AW        = $clog2(RAM_DEPTH);

    back_state_t state_reg, state_next;
    logic [2:0]                 open_reg, open_next;
    logic [CW-1:0]              count_reg [3];
    logic [CW-1:0]              count_next [3];
    logic [7:0]                 head_reg [3];
    logic [7:0]                 head_next [3];
    logic [SEG_COUNT_WIDTH-1:0] kept_reg [3];
    logic [SEG_COUNT_WIDTH-1:0] kept_next [3];
    logic [1:0]                 frame_reg, frame_next;
    logic [CW-1:0]              left_reg, left_next;
    logic [CW-1:0]              k_reg, k_next;
    logic [15:0]                seg_reg, seg_next;
    logic                       last_reg, last_next;
    logic [1:0]                 flush_reg, flush_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_aa_reg, out_aa_next;
    logic [1:0]  out_frame_reg, out_frame_next;
    logic [15:0] out_seg_reg, out_seg_next;
    logic        out_end_reg, out_end_next;
    logic        out_lor_reg, out_lor_next;

    logic [1:0]                 cur_f;
    logic                       cur_open;
    logic [CW-1:0]              cur_count;
    logic [7:0]                 cur_head;
    logic [SEG_COUNT_WIDTH-1:0] cur_kept;
    logic [SEG_COUNT_WIDTH-1:0] kept_inc;
    logic [CW-1:0]              c_inc;
    logic [CW-1:0]              m_eff;
    logic                       out_free, is_stop, take, opens, burst, burst_final;
    logic [2:0]                 open_after;
    logic                       flush_lor;

    logic             ld, ld_end, ld_lor;
    logic [7:0]       ld_aa;
    logic [1:0]       ld_frame;
    logic [15:0]      ld_seg;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_rdata;

    tfct_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_hold_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_cmd.aa),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        cur_f     = (state_reg == BK_FLUSH) ? flush_reg : q_cmd.frame;
        cur_open  = open_reg[cur_f];
        cur_count = count_reg[cur_f];
        cur_head  = head_reg[cur_f];
        cur_kept  = kept_reg[cur_f];
        kept_inc  = (cur_kept == '1) ? cur_kept : cur_kept + SEG_COUNT_WIDTH'(1);
        c_inc     = cur_count + CW'(1);
        out_free  = !out_valid_reg || m_ready;
        is_stop   = (q_cmd.aa == AA_STOP);

        if (min_segment_len == 5'd0) begin
            m_eff = CW'(1);
        end else if (int'(min_segment_len) > HOLD_DEPTH) begin
            m_eff = CW'(HOLD_DEPTH);
        end else begin
            m_eff = CW'(min_segment_len);
        end

        take        = (state_reg == BK_IDLE) && q_valid && out_free;
        opens       = take && !is_stop && !cur_open && (c_inc >= m_eff);
        burst       = opens && (c_inc > CW'(1));
        burst_final = (k_reg == left_reg - CW'(1));

        open_after = open_reg;
        open_after[cur_f] = !is_stop && (cur_open || opens);
        flush_lor  = ((open_reg >> (flush_reg + 2'd1)) == 3'd0);

        ram_we    = take && !is_stop && !cur_open;
        ram_waddr = AW'(cur_f) * AW'(HOLD_DEPTH) + AW'(cur_count);
        ram_raddr = AW'(frame_reg) * AW'(HOLD_DEPTH) + AW'(k_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (take) begin
                    if (burst) begin
                        state_next = BK_READ;
                    end else if (q_cmd.last) begin
                        state_next = BK_FLUSH;
                    end
                end
            end
            BK_READ: begin
                state_next = BK_DATA;
            end
            BK_DATA: begin
                if (out_free) begin
                    if (!burst_final) begin
                        state_next = BK_READ;
                    end else if (last_reg) begin
                        state_next = BK_FLUSH;
                    end else begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_FLUSH: begin
                if ((!cur_open || out_free) && flush_reg == 2'd2) begin
                    state_next = BK_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        open_next  = open_reg;
        count_next = count_reg;
        head_next  = head_reg;
        kept_next  = kept_reg;
        frame_next = frame_reg;
        left_next  = left_reg;
        k_next     = k_reg;
        seg_next   = seg_reg;
        last_next  = last_reg;
        flush_next = flush_reg;
        q_pop      = take;
        ld         = 1'b0;
        ld_aa      = cur_head;
        ld_frame   = cur_f;
        ld_seg     = 16'(cur_kept);
        ld_end     = 1'b0;
        ld_lor     = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (take) begin
                    frame_next = cur_f;
                    last_next  = q_cmd.last;
                    k_next     = '0;
                    flush_next = 2'd0;
                    ld_lor     = !(q_cmd.last && (open_after != 3'd0));
                    if (is_stop) begin
                        ld                = cur_open;
                        ld_end            = 1'b1;
                        open_next[cur_f]  = 1'b0;
                        count_next[cur_f] = '0;
                    end else if (cur_open) begin
                        ld               = 1'b1;
                        head_next[cur_f] = q_cmd.aa;
                    end else if (opens) begin
                        kept_next[cur_f]  = kept_inc;
                        open_next[cur_f]  = 1'b1;
                        count_next[cur_f] = CW'(1);
                        head_next[cur_f]  = q_cmd.aa;
                        left_next         = c_inc - CW'(1);
                        seg_next          = 16'(kept_inc);
                    end else begin
                        count_next[cur_f] = c_inc;
                    end
                end
            end
            BK_READ: begin
            end
            BK_DATA: begin
                if (out_free) begin
                    ld       = 1'b1;
                    ld_aa    = ram_rdata;
                    ld_frame = frame_reg;
                    ld_seg   = seg_reg;
                    ld_lor   = burst_final && !last_reg;
                    if (!burst_final) begin
                        k_next = k_reg + CW'(1);
                    end
                end
            end
            BK_FLUSH: begin
                if (!cur_open || out_free) begin
                    ld     = cur_open;
                    ld_end = 1'b1;
                    ld_lor = flush_lor;
                    if (flush_reg == 2'd2) begin
                        open_next  = 3'd0;
                        count_next = '{default: '0};
                        kept_next  = '{default: '0};
                        flush_next = 2'd0;
                    end else begin
                        flush_next = flush_reg + 2'd1;
                    end
                end
            end
        endcase

        out_aa_next    = out_aa_reg;
        out_frame_next = out_frame_reg;
        out_seg_next   = out_seg_reg;
        out_end_next   = out_end_reg;
        out_lor_next   = out_lor_reg;
        if (ld) begin
            out_valid_next = 1'b1;
            out_aa_next    = ld_aa;
            out_frame_next = ld_frame;
            out_seg_next   = ld_seg;
            out_end_next   = ld_end;
            out_lor_next   = ld_lor;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            open_reg      <= 3'd0;
            count_reg     <= '{default: '0};
            kept_reg      <= '{default: '0};
            flush_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            count_reg     <= count_next;
            kept_reg      <= kept_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg      <= head_next;
        frame_reg     <= frame_next;
        left_reg      <= left_next;
        k_reg         <= k_next;
        seg_reg       <= seg_next;
        last_reg      <= last_next;
        out_aa_reg    <= out_aa_next;
        out_frame_reg <= out_frame_next;
        out_seg_reg   <= out_seg_next;
        out_end_reg   <= out_end_next;
        out_lor_reg   <= out_lor_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_amino_acid     = out_aa_reg;
    assign m_frame_index    = out_frame_reg;
    assign m_segment_number = out_seg_reg;
    assign m_segment_end    = out_end_reg;
    assign m_last_of_run    = out_lor_reg;

endmodule

`default_nettype wire

>>> sv/three_frame_codon_translator.sv
// Top level of the three-frame codon translator: config register, front, queue, back.
// Depends on tfct_pkg, tfct_front, tfct_queue, tfct_back.
//
//   channel  | ports                                  | direction
//   ---------+----------------------------------------+----------
//   s_       | s_valid s_ready s_base_char s_last_base | request in
//   m_       | m_valid m_ready m_amino_acid ...        | result out
//   cfg_     | cfg_wr_en cfg_wr_data                   | write only
//
// The front takes one base per cycle while the 4-entry command queue has room.
// The back takes a command when idle with a free output register. A segment reaching
// min length emits its held amino acids, each via a registered RAM read; a last base
// flushes all three frames. Results sit in an output register, so m_ready low stalls
// only the back; the front keeps filling the queue. Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module three_frame_codon_translator #(
    parameter int HOLD_DEPTH      = tfct_pkg::HOLD_DEPTH_DEF,
    parameter int SEG_COUNT_WIDTH = tfct_pkg::SEG_COUNT_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_base_char,
    input  wire logic        s_last_base,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_amino_acid,
    output logic [1:0]       m_frame_index,
    output logic [15:0]      m_segment_number,
    output logic             m_segment_end,
    output logic             m_last_of_run
);
    import tfct_pkg::*;

    logic [4:0] min_len_reg, min_len_next;
    logic       push, q_full, q_valid, q_pop;
    cmd_t       front_cmd, q_cmd;

    always_comb begin
        min_len_next = cfg_wr_en ? cfg_wr_data : min_len_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= MIN_LEN_RESET;
        end else begin
            min_len_reg <= min_len_next;
        end
    end

    tfct_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_base_char (s_base_char),
        .s_last_base (s_last_base),
        .q_full      (q_full),
        .push        (push),
        .cmd         (front_cmd)
    );

    tfct_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .cmd_in  (front_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .cmd_out (q_cmd)
    );

    tfct_back #(
        .HOLD_DEPTH      (HOLD_DEPTH),
        .SEG_COUNT_WIDTH (SEG_COUNT_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .min_segment_len  (min_len_reg),
        .q_valid          (q_valid),
        .q_cmd            (q_cmd),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_amino_acid     (m_amino_acid),
        .m_frame_index    (m_frame_index),
        .m_segment_number (m_segment_number),
        .m_segment_end    (m_segment_end),
        .m_last_of_run    (m_last_of_run)
    );

endmodule

`default_nettype wire

>>> sv/tfct_checker.sv
// Port-level checks for the three-frame codon translator, bound to the top level.
// Depends on three_frame_codon_translator ports only.
`timescale 1ns / 1ps
`default_nettype none

module tfct_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_amino_acid,
    input wire logic [1:0]  m_frame_index,
    input wire logic [15:0] m_segment_number,
    input wire logic        m_segment_end,
    input wire logic        m_last_of_run
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_amino_acid) && $stable(m_frame_index)
            && $stable(m_segment_number) && $stable(m_segment_end) && $stable(m_last_of_run))
        else $error("result changed while stalled");

    a_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frame_index != 2'd3)
        else $error("frame index out of range");

    a_seg_num: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_segment_number != 16'd0)
        else $error("result outside a kept segment");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind three_frame_codon_translator tfct_checker u_tfct_checker (.*);

`default_nettype wire
